@@ hdl/vpc_pkg.sv @@
// Shared types, constants and tables for the voxel polarization color core.
`default_nettype none

package vpc_pkg;

	localparam int GRID_SIZE = 64;

	localparam int COORD_W = 6;
	localparam int COMP_W  = 16;
	localparam int R2_W    = 24;
	localparam int CHAN_W  = 8;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int DEG_Q16   = 65536;
	localparam int FULL_TURN = 360 * DEG_Q16;
	localparam int HALF_TURN = 180 * DEG_Q16;
	localparam int SECTOR_W  = 60 * DEG_Q16;
	localparam int SECTORS   = 6;

	localparam int CORDIC_STEPS    = 20;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int PRESCALE_SH     = 14;

	localparam int VEC_W = 33;
	localparam int ANG_W = 26;
	localparam int HUE_W = 25;
	localparam int T_W   = 22;

	localparam int RAMP_MUL    = 510;
	localparam int RAMP_FRAC   = 16;
	localparam int RAMP_SUM_W  = 32;
	localparam int RAMP_N_W    = 15;
	localparam int RECIP_K     = 34953;
	localparam int RECIP_K_W   = 16;
	localparam int RECIP_SHIFT = 22;
	localparam int RECIP_P_W   = RAMP_N_W + RECIP_K_W;

	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;
	localparam logic [CHAN_W-1:0] CHAN_DIM  = 8'd80;
	localparam logic [CHAN_W-1:0] CHAN_OFF  = 8'd0;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLAR_ENABLE,
		REG_SLICE_MODE,
		REG_SLICE_X,
		REG_SLICE_Y,
		REG_SLICE_Z,
		REG_CENTRE_POS,
		REG_MARKER_OFFSET,
		REG_FAR_R2_CODE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SLICE_FULL,
		SLICE_XY,
		SLICE_YZ,
		SLICE_ZX
	} slice_mode_t;

	typedef enum logic [2:0] {
		SEC_R_TO_Y,
		SEC_Y_TO_G,
		SEC_G_TO_C,
		SEC_C_TO_B,
		SEC_B_TO_M,
		SEC_M_TO_R
	} hue_sector_t;

	typedef struct packed {
		logic                polar_enable;
		slice_mode_t         slice_mode;
		logic [COORD_W-1:0]  slice_x;
		logic [COORD_W-1:0]  slice_y;
		logic [COORD_W-1:0]  slice_z;
		logic [COORD_W-1:0]  centre_pos;
		logic [COORD_W-1:0]  marker_offset;
		logic [R2_W-1:0]     far_r2_code;
	} cfg_t;

	typedef struct packed {
		logic visible;
		logic polar;
		logic active;
		logic r2_zero;
		logic marker;
	} side_t;

	typedef struct packed {
		vec_t a;
		vec_t b;
		ang_t z;
	} cordic_t;

	function automatic ang_t atan_q16(input int idx);
		case (idx)
			0:       return ang_t'(2949120);
			1:       return ang_t'(1740967);
			2:       return ang_t'(919879);
			3:       return ang_t'(466945);
			4:       return ang_t'(234379);
			5:       return ang_t'(117304);
			6:       return ang_t'(58666);
			7:       return ang_t'(29335);
			8:       return ang_t'(14668);
			9:       return ang_t'(7334);
			10:      return ang_t'(3667);
			11:      return ang_t'(1833);
			12:      return ang_t'(917);
			13:      return ang_t'(458);
			14:      return ang_t'(229);
			15:      return ang_t'(115);
			16:      return ang_t'(57);
			17:      return ang_t'(29);
			18:      return ang_t'(14);
			19:      return ang_t'(7);
			default: return ang_t'(0);
		endcase
	endfunction

endpackage

`default_nettype wire

@@ hdl/vpc_vox_in_if.sv @@
// Voxel request channel: handshake and voxel fields.
`default_nettype none

interface vpc_vox_in_if;
	logic                                valid;
	logic                                ready;
	logic [vpc_pkg::COORD_W-1:0]         x_pos;
	logic [vpc_pkg::COORD_W-1:0]         y_pos;
	logic [vpc_pkg::COORD_W-1:0]         z_pos;
	logic signed [vpc_pkg::COMP_W-1:0]   u_comp;
	logic signed [vpc_pkg::COMP_W-1:0]   v_comp;
	logic [vpc_pkg::R2_W-1:0]            r2_value;
	logic                                is_active;

	modport source (output valid, x_pos, y_pos, z_pos, u_comp, v_comp, r2_value, is_active,
		input ready);
	modport sink (input valid, x_pos, y_pos, z_pos, u_comp, v_comp, r2_value, is_active,
		output ready);
endinterface

`default_nettype wire

@@ hdl/vpc_vox_out_if.sv @@
// Color request channel: handshake and RGBA fields.
`default_nettype none

interface vpc_vox_out_if;
	logic                         valid;
	logic                         ready;
	logic [vpc_pkg::CHAN_W-1:0]   red;
	logic [vpc_pkg::CHAN_W-1:0]   green;
	logic [vpc_pkg::CHAN_W-1:0]   blue;
	logic [vpc_pkg::CHAN_W-1:0]   alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

`default_nettype wire

@@ hdl/vpc_cfg_if.sv @@
// Configuration write channel: handshake, register index and data.
`default_nettype none

interface vpc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [vpc_pkg::CFG_IDX_W-1:0]    index;
	logic [vpc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/vpc_prep.sv @@
// First pipeline stage: slice test, rule flags and CORDIC pre-rotation.
`default_nettype none

module vpc_prep #(
	parameter int GRID_SIZE = vpc_pkg::GRID_SIZE
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              vld_in,
	input  wire vpc_pkg::cfg_t                     cfg,
	input  wire logic [vpc_pkg::COORD_W-1:0]       x_pos,
	input  wire logic [vpc_pkg::COORD_W-1:0]       y_pos,
	input  wire logic [vpc_pkg::COORD_W-1:0]       z_pos,
	input  wire logic signed [vpc_pkg::COMP_W-1:0] u_comp,
	input  wire logic signed [vpc_pkg::COMP_W-1:0] v_comp,
	input  wire logic [vpc_pkg::R2_W-1:0]          r2_value,
	input  wire logic                              is_active,
	output logic                                   vld_s1,
	output vpc_pkg::side_t                         side_s1,
	output vpc_pkg::cordic_t                       vec_s1
);

	vpc_pkg::side_t            side_d;
	vpc_pkg::cordic_t          vec_d;
	vpc_pkg::vec_t             u_sc;
	vpc_pkg::vec_t             v_sc;
	logic [vpc_pkg::COORD_W:0] marker_x;

	always_comb begin
		case (cfg.slice_mode)
			vpc_pkg::SLICE_XY: side_d.visible = (z_pos == cfg.slice_z);
			vpc_pkg::SLICE_YZ: side_d.visible = (x_pos == cfg.slice_x);
			vpc_pkg::SLICE_ZX: side_d.visible = (y_pos == cfg.slice_y);
			default:           side_d.visible = 1'b1;
		endcase
		if (int'(x_pos) >= GRID_SIZE || int'(y_pos) >= GRID_SIZE ||
				int'(z_pos) >= GRID_SIZE) begin
			side_d.visible = 1'b0;
		end

		marker_x = {1'b0, cfg.centre_pos} + {1'b0, cfg.marker_offset};
		side_d.marker = ({1'b0, x_pos} == marker_x) && (y_pos == cfg.centre_pos) &&
			(z_pos == cfg.centre_pos);
		side_d.polar = cfg.polar_enable && (r2_value != cfg.far_r2_code) &&
			((u_comp != '0) || (v_comp != '0));
		side_d.active  = is_active;
		side_d.r2_zero = (r2_value == '0);

		u_sc = vpc_pkg::vec_t'(u_comp) <<< vpc_pkg::PRESCALE_SH;
		v_sc = vpc_pkg::vec_t'(v_comp) <<< vpc_pkg::PRESCALE_SH;
		// rotate by half a turn when the negated u lands in the left half plane
		if (!u_comp[vpc_pkg::COMP_W-1] && (u_comp != '0)) begin
			vec_d.a = u_sc;
			vec_d.b = v_sc;
			vec_d.z = vpc_pkg::ang_t'(vpc_pkg::HALF_TURN);
		end else begin
			vec_d.a = -u_sc;
			vec_d.b = -v_sc;
			vec_d.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			vec_s1  <= vec_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/vpc_cordic_stage.sv @@
// One CORDIC vectoring pipeline stage covering a fixed pair of iterations.
`default_nettype none

module vpc_cordic_stage #(
	parameter int FIRST = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             vld_in,
	input  wire vpc_pkg::side_t   side_in,
	input  wire vpc_pkg::cordic_t vec_in,
	output logic                  vld_s1,
	output vpc_pkg::side_t        side_s1,
	output vpc_pkg::cordic_t      vec_s1
);

	vpc_pkg::cordic_t cur;
	vpc_pkg::cordic_t nxt;
	vpc_pkg::vec_t    sh_a;
	vpc_pkg::vec_t    sh_b;

	always_comb begin
		cur = vec_in;
		nxt = vec_in;
		sh_a = '0;
		sh_b = '0;
		for (int k = 0; k < vpc_pkg::STEPS_PER_STAGE; k++) begin
			sh_a = $signed(cur.a) >>> (FIRST + k);
			sh_b = $signed(cur.b) >>> (FIRST + k);
			if (!cur.b[vpc_pkg::VEC_W-1] && (cur.b != '0)) begin
				nxt.a = cur.a + sh_b;
				nxt.b = cur.b - sh_a;
				nxt.z = cur.z + vpc_pkg::atan_q16(FIRST + k);
			end else begin
				nxt.a = cur.a - sh_b;
				nxt.b = cur.b + sh_a;
				nxt.z = cur.z - vpc_pkg::atan_q16(FIRST + k);
			end
			cur = nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			vec_s1  <= cur;
		end
	end

endmodule

`default_nettype wire

@@ hdl/vpc_colour.sv @@
// Hue wrap, sector split, ramp scaling and final color priority.
`default_nettype none

module vpc_colour (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        vld_in,
	input  wire vpc_pkg::side_t              side_in,
	input  wire vpc_pkg::ang_t               z_in,
	output logic                             vld_s4,
	output logic [vpc_pkg::CHAN_W-1:0]       red_s4,
	output logic [vpc_pkg::CHAN_W-1:0]       green_s4,
	output logic [vpc_pkg::CHAN_W-1:0]       blue_s4,
	output logic [vpc_pkg::CHAN_W-1:0]       alpha_s4
);

	logic                               vld_s1, vld_s2, vld_s3;
	vpc_pkg::side_t                     side_s1, side_s2, side_s3;
	logic [vpc_pkg::HUE_W-1:0]          hue_s1;
	vpc_pkg::hue_sector_t               sec_s2, sec_s3;
	logic [vpc_pkg::T_W-1:0]            t_s2;
	logic [vpc_pkg::RAMP_N_W-1:0]       nup_s3, ndn_s3;

	vpc_pkg::ang_t                      hue_wrap;
	vpc_pkg::hue_sector_t               sec_d;
	logic [vpc_pkg::HUE_W-1:0]          base_d;
	logic [vpc_pkg::T_W-1:0]            tdn;
	logic [vpc_pkg::RAMP_SUM_W-1:0]     sum_up, sum_dn;
	logic [vpc_pkg::RECIP_P_W-1:0]      q_up, q_dn;
	logic [vpc_pkg::CHAN_W-1:0]         up, down;
	logic [vpc_pkg::CHAN_W-1:0]         hr, hg, hb;
	logic [vpc_pkg::CHAN_W-1:0]         r_d, g_d, b_d, a_d;

	// stage 1: wrap into one turn
	always_comb begin
		hue_wrap = z_in;
		if (z_in[vpc_pkg::ANG_W-1]) begin
			hue_wrap = z_in + vpc_pkg::ang_t'(vpc_pkg::FULL_TURN);
		end
	end

	// stage 2: sector and offset within it
	always_comb begin
		sec_d  = vpc_pkg::SEC_R_TO_Y;
		base_d = '0;
		for (int k = 1; k < vpc_pkg::SECTORS; k++) begin
			if (hue_s1 >= vpc_pkg::HUE_W'(k * vpc_pkg::SECTOR_W)) begin
				sec_d  = vpc_pkg::hue_sector_t'(k);
				base_d = vpc_pkg::HUE_W'(k * vpc_pkg::SECTOR_W);
			end
		end
	end

	// stage 3: ramp numerators, already divided by the fraction scale
	always_comb begin
		tdn    = vpc_pkg::T_W'(vpc_pkg::SECTOR_W) - t_s2;
		sum_up = vpc_pkg::RAMP_SUM_W'(t_s2) * vpc_pkg::RAMP_SUM_W'(vpc_pkg::RAMP_MUL) +
			vpc_pkg::RAMP_SUM_W'(vpc_pkg::SECTOR_W);
		sum_dn = vpc_pkg::RAMP_SUM_W'(tdn) * vpc_pkg::RAMP_SUM_W'(vpc_pkg::RAMP_MUL) +
			vpc_pkg::RAMP_SUM_W'(vpc_pkg::SECTOR_W);
	end

	// stage 4: divide by 120 through the reciprocal, build RGB, apply overrides
	always_comb begin
		q_up = vpc_pkg::RECIP_P_W'(nup_s3) * vpc_pkg::RECIP_P_W'(vpc_pkg::RECIP_K);
		q_dn = vpc_pkg::RECIP_P_W'(ndn_s3) * vpc_pkg::RECIP_P_W'(vpc_pkg::RECIP_K);
		up   = q_up[vpc_pkg::RECIP_SHIFT +: vpc_pkg::CHAN_W];
		down = q_dn[vpc_pkg::RECIP_SHIFT +: vpc_pkg::CHAN_W];

		case (sec_s3)
			vpc_pkg::SEC_R_TO_Y: begin
				hr = vpc_pkg::CHAN_FULL; hg = up;                 hb = vpc_pkg::CHAN_OFF;
			end
			vpc_pkg::SEC_Y_TO_G: begin
				hr = down;               hg = vpc_pkg::CHAN_FULL; hb = vpc_pkg::CHAN_OFF;
			end
			vpc_pkg::SEC_G_TO_C: begin
				hr = vpc_pkg::CHAN_OFF;  hg = vpc_pkg::CHAN_FULL; hb = up;
			end
			vpc_pkg::SEC_C_TO_B: begin
				hr = vpc_pkg::CHAN_OFF;  hg = down;               hb = vpc_pkg::CHAN_FULL;
			end
			vpc_pkg::SEC_B_TO_M: begin
				hr = up;                 hg = vpc_pkg::CHAN_OFF;  hb = vpc_pkg::CHAN_FULL;
			end
			default: begin
				hr = vpc_pkg::CHAN_FULL; hg = vpc_pkg::CHAN_OFF;  hb = down;
			end
		endcase

		r_d = vpc_pkg::CHAN_OFF;
		g_d = vpc_pkg::CHAN_OFF;
		b_d = vpc_pkg::CHAN_OFF;
		a_d = vpc_pkg::CHAN_OFF;
		if (side_s3.visible) begin
			if (side_s3.polar) begin
				r_d = hr; g_d = hg; b_d = hb; a_d = vpc_pkg::CHAN_FULL;
			end
			if (side_s3.active) begin
				r_d = vpc_pkg::CHAN_FULL; g_d = vpc_pkg::CHAN_FULL;
				b_d = vpc_pkg::CHAN_FULL; a_d = vpc_pkg::CHAN_FULL;
			end
			if (side_s3.r2_zero) begin
				r_d = vpc_pkg::CHAN_DIM;  g_d = vpc_pkg::CHAN_FULL;
				b_d = vpc_pkg::CHAN_DIM;  a_d = vpc_pkg::CHAN_FULL;
			end
			if (side_s3.marker) begin
				r_d = vpc_pkg::CHAN_FULL; g_d = vpc_pkg::CHAN_DIM;
				b_d = vpc_pkg::CHAN_DIM;  a_d = vpc_pkg::CHAN_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_in;
			hue_s1   <= vpc_pkg::HUE_W'(hue_wrap);
			side_s2  <= side_s1;
			sec_s2   <= sec_d;
			t_s2     <= vpc_pkg::T_W'(hue_s1 - base_d);
			side_s3  <= side_s2;
			sec_s3   <= sec_s2;
			nup_s3   <= sum_up[vpc_pkg::RAMP_FRAC +: vpc_pkg::RAMP_N_W];
			ndn_s3   <= sum_dn[vpc_pkg::RAMP_FRAC +: vpc_pkg::RAMP_N_W];
			red_s4   <= r_d;
			green_s4 <= g_d;
			blue_s4  <= b_d;
			alpha_s4 <= a_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (sec_s2 == vpc_pkg::SEC_R_TO_Y || sec_s2 == vpc_pkg::SEC_Y_TO_G ||
			sec_s2 == vpc_pkg::SEC_G_TO_C || sec_s2 == vpc_pkg::SEC_C_TO_B ||
			sec_s2 == vpc_pkg::SEC_B_TO_M || sec_s2 == vpc_pkg::SEC_M_TO_R))
		else $error("hue sector out of range");

	a_ramp_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (!q_up[vpc_pkg::RECIP_P_W-1] && !q_dn[vpc_pkg::RECIP_P_W-1]))
		else $error("ramp quotient exceeds channel range");

	a_alpha_codes: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (alpha_s4 == vpc_pkg::CHAN_FULL ||
			(alpha_s4 == vpc_pkg::CHAN_OFF && red_s4 == vpc_pkg::CHAN_OFF &&
			green_s4 == vpc_pkg::CHAN_OFF && blue_s4 == vpc_pkg::CHAN_OFF)))
		else $error("transparent color with nonzero channels");
`endif

endmodule

`default_nettype wire

@@ hdl/voxel_polarisation_colour_core.sv @@
// Top level of the voxel polarization color core: registers, pipeline and handshakes.
//
// Usage:
//   voxel  - request channel carrying one voxel (coordinates, u/v components,
//            squared radius, active flag); taken when valid and ready are high.
//   colour - request channel returning one RGBA color per voxel, in order.
//   cfg    - register write channel (index, data); always ready. Write only
//            while no voxel is in flight.
// Pipeline: a slice test and pre-rotation stage, then ten CORDIC stages of
//   two iterations each, then the hue wrap, sector split, ramp scaling and
//   color selection stages, ending on the colour channel.
// Throughput: one voxel per cycle while the colour channel does not stall; every stage advances together.
// Reset: arst_n clears all valid bits and loads register defaults (centre 32,
//   far code all ones, the rest zero).
// Stall: while a color waits and colour.ready is low, the whole pipeline
//   holds and voxel.ready drops; a free output register keeps it moving.
`default_nettype none

module voxel_polarisation_colour_core #(
	parameter int GRID_SIZE = vpc_pkg::GRID_SIZE
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	vpc_vox_in_if.sink   voxel,
	vpc_vox_out_if.source colour,
	vpc_cfg_if.sink      cfg
);

	vpc_pkg::cfg_t    cfg_q;
	logic             en;

	logic             vld_c  [vpc_pkg::CORDIC_STAGES+1];
	vpc_pkg::side_t   side_c [vpc_pkg::CORDIC_STAGES+1];
	vpc_pkg::cordic_t vec_c  [vpc_pkg::CORDIC_STAGES+1];

	assign en          = !colour.valid || colour.ready;
	assign voxel.ready = en;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polar_enable  <= 1'b0;
			cfg_q.slice_mode    <= vpc_pkg::SLICE_FULL;
			cfg_q.slice_x       <= '0;
			cfg_q.slice_y       <= '0;
			cfg_q.slice_z       <= '0;
			cfg_q.centre_pos    <= vpc_pkg::COORD_W'(32);
			cfg_q.marker_offset <= '0;
			cfg_q.far_r2_code   <= '1;
		end else if (cfg.valid) begin
			case (vpc_pkg::cfg_reg_t'(cfg.index))
				vpc_pkg::REG_POLAR_ENABLE:  cfg_q.polar_enable  <= cfg.data[0];
				vpc_pkg::REG_SLICE_MODE:
					cfg_q.slice_mode <= vpc_pkg::slice_mode_t'(cfg.data[1:0]);
				vpc_pkg::REG_SLICE_X:       cfg_q.slice_x       <= cfg.data[vpc_pkg::COORD_W-1:0];
				vpc_pkg::REG_SLICE_Y:       cfg_q.slice_y       <= cfg.data[vpc_pkg::COORD_W-1:0];
				vpc_pkg::REG_SLICE_Z:       cfg_q.slice_z       <= cfg.data[vpc_pkg::COORD_W-1:0];
				vpc_pkg::REG_CENTRE_POS:    cfg_q.centre_pos    <= cfg.data[vpc_pkg::COORD_W-1:0];
				vpc_pkg::REG_MARKER_OFFSET: cfg_q.marker_offset <= cfg.data[vpc_pkg::COORD_W-1:0];
				vpc_pkg::REG_FAR_R2_CODE:   cfg_q.far_r2_code   <= cfg.data[vpc_pkg::R2_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vpc_prep #(
		.GRID_SIZE (GRID_SIZE)
	) u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld_in    (voxel.valid),
		.cfg       (cfg_q),
		.x_pos     (voxel.x_pos),
		.y_pos     (voxel.y_pos),
		.z_pos     (voxel.z_pos),
		.u_comp    (voxel.u_comp),
		.v_comp    (voxel.v_comp),
		.r2_value  (voxel.r2_value),
		.is_active (voxel.is_active),
		.vld_s1    (vld_c[0]),
		.side_s1   (side_c[0]),
		.vec_s1    (vec_c[0])
	);

	for (genvar g = 0; g < vpc_pkg::CORDIC_STAGES; g++) begin : g_cordic
		vpc_cordic_stage #(
			.FIRST (g * vpc_pkg::STEPS_PER_STAGE)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld_c[g]),
			.side_in (side_c[g]),
			.vec_in  (vec_c[g]),
			.vld_s1  (vld_c[g+1]),
			.side_s1 (side_c[g+1]),
			.vec_s1  (vec_c[g+1])
		);
	end

	vpc_colour u_colour (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_c[vpc_pkg::CORDIC_STAGES]),
		.side_in  (side_c[vpc_pkg::CORDIC_STAGES]),
		.z_in     (vec_c[vpc_pkg::CORDIC_STAGES].z),
		.vld_s4   (colour.valid),
		.red_s4   (colour.red),
		.green_s4 (colour.green),
		.blue_s4  (colour.blue),
		.alpha_s4 (colour.alpha)
	);

`ifndef NO_ASSERTIONS
	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!voxel.ready |-> (colour.valid && !colour.ready))
		else $error("voxel request refused without a waiting color");
`endif

endmodule

`default_nettype wire

@@ tb/voxel_polarisation_colour_core_tb.sv @@
// Self-checking testbench for the voxel polarization color core: slices, hue wheel and overlays.
`timescale 1ns / 100ps

module voxel_polarisation_colour_core_tb;
	import vpc_pkg::*;

	localparam longint DEG_STEP   = 65536;
	localparam longint TURN       = 360 * DEG_STEP;
	localparam longint HUE_SECTOR = 60 * DEG_STEP;
	localparam int     RAND_ITEMS = 183;
	localparam int     RAND_SETS  = 10;

	typedef struct packed {
		logic [5:0]  x;
		logic [5:0]  y;
		logic [5:0]  z;
		logic [15:0] u;
		logic [15:0] v;
		logic [23:0] r2;
		logic        act;
	} vox_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        vox_valid = 1'b0;
	vox_t        vox_drv = '0;
	logic        col_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	cfg_reg_t    cfg_index = REG_POLAR_ENABLE;
	logic [23:0] cfg_data = '0;

	vpc_vox_in_if  vox_if ();
	vpc_vox_out_if col_if ();
	vpc_cfg_if     cfg_if ();

	assign vox_if.valid     = vox_valid;
	assign vox_if.x_pos     = vox_drv.x;
	assign vox_if.y_pos     = vox_drv.y;
	assign vox_if.z_pos     = vox_drv.z;
	assign vox_if.u_comp    = vox_drv.u;
	assign vox_if.v_comp    = vox_drv.v;
	assign vox_if.r2_value  = vox_drv.r2;
	assign vox_if.is_active = vox_drv.act;
	assign col_if.ready     = col_ready;
	assign cfg_if.valid     = cfg_valid;
	assign cfg_if.index     = cfg_index;
	assign cfg_if.data      = cfg_data;

	voxel_polarisation_colour_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.voxel  (vox_if),
		.colour (col_if),
		.cfg    (cfg_if)
	);

	always #4 clk = ~clk;

	longint atan_step [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
	int idle_levels [4] = '{0, 5, 20, 50};

	cfg_t  regs;
	vox_t  vox_q [$];
	rgba_t colour_q [$];
	vox_t  cur_vox = '0;
	logic  vox_held = 1'b0;
	int    in_gap = 0;
	int    out_gap = 0;
	int    in_idle_pct = 0;
	int    out_idle_pct = 0;
	logic  rdy;
	rgba_t want;
	rgba_t got;
	int    errors = 0;
	int    n_sent = 0;
	int    n_checked = 0;
	int    n_hidden = 0;
	int    n_hue = 0;
	int    n_marker = 0;

	function automatic int draw_gap(int pct);
		int r;
		if ($urandom_range(0, 99) >= pct)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		if (r < 9)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic longint cordic_hue(longint u, longint v);
		longint a, b, ang, na, nb;
		a = -u * 16384;
		b = -v * 16384;
		ang = 0;
		if (a < 0) begin
			a = -a;
			b = -b;
			ang = 180 * DEG_STEP;
		end
		for (int i = 0; i < 20; i++) begin
			if (b > 0) begin
				na = a + (b >>> i);
				nb = b - (a >>> i);
				ang += atan_step[i];
			end else begin
				na = a - (b >>> i);
				nb = b + (a >>> i);
				ang -= atan_step[i];
			end
			a = na;
			b = nb;
		end
		while (ang < 0)
			ang += TURN;
		while (ang >= TURN)
			ang -= TURN;
		return ang;
	endfunction

	function automatic longint ramp(longint t);
		return (510 * t + HUE_SECTOR) / (2 * HUE_SECTOR);
	endfunction

	function automatic rgba_t predict_colour(vox_t vx);
		rgba_t  c;
		logic   visible;
		longint hue, s, t, up, dn;
		case (regs.slice_mode)
			SLICE_XY: visible = (vx.z == regs.slice_z);
			SLICE_YZ: visible = (vx.x == regs.slice_x);
			SLICE_ZX: visible = (vx.y == regs.slice_y);
			default:  visible = 1'b1;
		endcase
		c = '0;
		if (!visible) begin
			n_hidden++;
			return c;
		end
		if (regs.polar_enable && vx.r2 != regs.far_r2_code && (vx.u != 0 || vx.v != 0)) begin
			n_hue++;
			hue = cordic_hue(longint'($signed(vx.u)), longint'($signed(vx.v)));
			s = hue / HUE_SECTOR;
			t = hue - s * HUE_SECTOR;
			up = ramp(t);
			dn = ramp(HUE_SECTOR - t);
			c.alpha = CHAN_FULL;
			case (hue_sector_t'(s[2:0]))
				SEC_R_TO_Y: begin
					c.red = CHAN_FULL; c.green = up[7:0]; c.blue = CHAN_OFF;
				end
				SEC_Y_TO_G: begin
					c.red = dn[7:0]; c.green = CHAN_FULL; c.blue = CHAN_OFF;
				end
				SEC_G_TO_C: begin
					c.red = CHAN_OFF; c.green = CHAN_FULL; c.blue = up[7:0];
				end
				SEC_C_TO_B: begin
					c.red = CHAN_OFF; c.green = dn[7:0]; c.blue = CHAN_FULL;
				end
				SEC_B_TO_M: begin
					c.red = up[7:0]; c.green = CHAN_OFF; c.blue = CHAN_FULL;
				end
				default: begin
					c.red = CHAN_FULL; c.green = CHAN_OFF; c.blue = dn[7:0];
				end
			endcase
		end
		if (vx.act)
			c = {CHAN_FULL, CHAN_FULL, CHAN_FULL, CHAN_FULL};
		if (vx.r2 == 0)
			c = {CHAN_DIM, CHAN_FULL, CHAN_DIM, CHAN_FULL};
		if (int'(vx.x) == int'(regs.centre_pos) + int'(regs.marker_offset)
				&& vx.y == regs.centre_pos && vx.z == regs.centre_pos) begin
			n_marker++;
			c = {CHAN_FULL, CHAN_DIM, CHAN_DIM, CHAN_FULL};
		end
		return c;
	endfunction

	function automatic logic [15:0] random_comp();
		int r;
		int sv;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			case ($urandom_range(0, 4))
				0: sv = -32768;
				1: sv = -1;
				2: sv = 0;
				3: sv = 1;
				default: sv = 32767;
			endcase
		end else if (r < 35) begin
			sv = int'($urandom_range(0, 128)) - 64;
		end else begin
			sv = $urandom;
		end
		return sv[15:0];
	endfunction

	function automatic vox_t random_vox();
		vox_t vx;
		int   rnd;
		int   sel;
		int   sum;
		rnd = $urandom;
		vx.x = rnd[5:0];
		vx.y = rnd[11:6];
		vx.z = rnd[17:12];
		if ($urandom_range(0, 9) < 7) begin
			case (regs.slice_mode)
				SLICE_XY: vx.z = regs.slice_z;
				SLICE_YZ: vx.x = regs.slice_x;
				SLICE_ZX: vx.y = regs.slice_y;
				default: ;
			endcase
		end
		sel = $urandom_range(0, 99);
		rnd = $urandom;
		if (sel < 10)
			vx.r2 = '0;
		else if (sel < 20)
			vx.r2 = regs.far_r2_code;
		else if (sel < 30)
			vx.r2 = 24'($urandom_range(1, 1000));
		else
			vx.r2 = rnd[23:0];
		sel = $urandom_range(0, 99);
		if (sel < 5) begin
			vx.u = '0;
			vx.v = '0;
		end else if (sel < 10) begin
			vx.u = '0;
			vx.v = random_comp();
		end else if (sel < 15) begin
			vx.u = random_comp();
			vx.v = '0;
		end else begin
			vx.u = random_comp();
			vx.v = random_comp();
		end
		vx.act = ($urandom_range(0, 99) < 15);
		if ($urandom_range(0, 99) < 6) begin
			sum = int'(regs.centre_pos) + int'(regs.marker_offset);
			vx.x = sum[5:0];
			vx.y = regs.centre_pos;
			vx.z = regs.centre_pos;
		end
		return vx;
	endfunction

	function automatic logic [23:0] junk(int w, logic [23:0] val);
		logic [23:0] r;
		r = 24'($urandom);
		if ($urandom_range(0, 1))
			r = '0;
		return val | ((r >> w) << w);
	endfunction

	task automatic add_vox(int x, int y, int z, int u, int v, int r2, int act);
		vox_t vx;
		vx.x = x[5:0];
		vx.y = y[5:0];
		vx.z = z[5:0];
		vx.u = u[15:0];
		vx.v = v[15:0];
		vx.r2 = r2[23:0];
		vx.act = act[0];
		vox_q.push_back(vx);
	endtask

	task automatic reg_write(cfg_reg_t idx, logic [23:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_POLAR_ENABLE:  regs.polar_enable = val[0];
			REG_SLICE_MODE:    regs.slice_mode = slice_mode_t'(val[1:0]);
			REG_SLICE_X:       regs.slice_x = val[5:0];
			REG_SLICE_Y:       regs.slice_y = val[5:0];
			REG_SLICE_Z:       regs.slice_z = val[5:0];
			REG_CENTRE_POS:    regs.centre_pos = val[5:0];
			REG_MARKER_OFFSET: regs.marker_offset = val[5:0];
			REG_FAR_R2_CODE:   regs.far_r2_code = val;
			default: ;
		endcase
	endtask

	task automatic load_config(logic [23:0] pe, logic [23:0] mode, logic [23:0] sx,
			logic [23:0] sy, logic [23:0] sz, logic [23:0] cp, logic [23:0] mo,
			logic [23:0] far);
		reg_write(REG_POLAR_ENABLE, pe);
		reg_write(REG_SLICE_MODE, mode);
		reg_write(REG_SLICE_X, sx);
		reg_write(REG_SLICE_Y, sy);
		reg_write(REG_SLICE_Z, sz);
		reg_write(REG_CENTRE_POS, cp);
		reg_write(REG_MARKER_OFFSET, mo);
		reg_write(REG_FAR_R2_CODE, far);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		int waited;
		while (vox_q.size() != 0 || vox_held)
			@(posedge clk);
		waited = 0;
		while (colour_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (colour_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected colours never arrived", $time, colour_q.size());
			colour_q.delete();
		end
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vox_valid <= 1'b0;
			vox_held = 1'b0;
			in_gap = 0;
		end else begin
			if (vox_valid && vox_if.ready) begin
				colour_q.push_back(predict_colour(cur_vox));
				vox_held = 1'b0;
				n_sent++;
			end
			if (!vox_held) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (vox_q.size() != 0) begin
					cur_vox = vox_q.pop_front();
					vox_held = 1'b1;
					in_gap = draw_gap(in_idle_pct);
				end
			end
			vox_valid <= vox_held;
			vox_drv <= cur_vox;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (col_if.valid && col_ready) begin
				n_checked++;
				got = {col_if.red, col_if.green, col_if.blue, col_if.alpha};
				if (colour_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected colour, expected none, actual %0d/%0d/%0d/%0d",
						$time, got.red, got.green, got.blue, got.alpha);
				end else begin
					want = colour_q.pop_front();
					if (want.red != got.red || want.green != got.green
							|| want.blue != got.blue || want.alpha != got.alpha) begin
						errors++;
						$display("%0t: colour mismatch, expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
							$time, want.red, want.green, want.blue, want.alpha,
							got.red, got.green, got.blue, got.alpha);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
				out_gap = draw_gap(out_idle_pct);
			end
			col_ready <= rdy;
		end
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int ph;
		int mode;
		regs.polar_enable = 1'b0;
		regs.slice_mode = SLICE_FULL;
		regs.slice_x = '0;
		regs.slice_y = '0;
		regs.slice_z = '0;
		regs.centre_pos = 6'd32;
		regs.marker_offset = '0;
		regs.far_r2_code = 24'hFFFFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: hue off, marker at the centre
		add_vox(1, 2, 3, 32767, 0, 100, 0);
		add_vox(0, 0, 0, 0, 0, 0, 0);
		add_vox(32, 32, 32, 5, 5, 77, 0);
		drain();

		load_config(1, 24'(SLICE_FULL), 0, 0, 0, 20, 5, 24'h00ABCD);
		add_vox(0, 0, 0, 0, 0, 100, 0);
		add_vox(1, 1, 1, 32767, 0, 100, 0);
		add_vox(2, 2, 2, -32768, 0, 100, 0);
		add_vox(3, 3, 3, 0, 32767, 100, 0);
		add_vox(4, 4, 4, 0, -32768, 100, 0);
		add_vox(5, 5, 5, -32768, -32768, 100, 0);
		add_vox(6, 6, 6, 32767, 32767, 100, 0);
		add_vox(7, 7, 7, 32767, -32768, 100, 0);
		add_vox(8, 8, 8, 1, 0, 100, 0);
		add_vox(9, 9, 9, -1, 1, 100, 0);
		add_vox(10, 10, 10, 100, 200, 24'h00ABCD, 0);
		add_vox(11, 11, 11, 5, -7, 24'hFFFFFF, 0);
		add_vox(12, 12, 12, 300, 0, 50, 1);
		add_vox(13, 13, 13, 300, 0, 0, 1);
		add_vox(25, 20, 20, 300, 0, 0, 1);
		add_vox(63, 63, 63, -1, -1, 1, 0);
		add_vox(30, 40, 50, -12345, 23456, 9, 0);
		drain();

		// marker past the grid edge, xy slice
		load_config(1, 24'(SLICE_XY), 0, 0, 7, 40, 30, 24'h000001);
		add_vox(6, 40, 7, 10, 10, 5, 0);
		add_vox(6, 40, 8, 10, 10, 5, 0);
		add_vox(0, 0, 7, 0, 0, 5, 1);
		add_vox(63, 63, 7, 0, 0, 0, 0);
		drain();

		for (ph = 0; ph < RAND_SETS; ph++) begin
			if (ph == 0) begin
				load_config(1, 24'(SLICE_FULL), 0, 0, 0, 0, 0, 0);
			end else if (ph == 1) begin
				load_config(1, 24'(SLICE_ZX), 63, 63, 63, 63, 63, 24'hFFFFFF);
			end else begin
				mode = ph % 4;
				load_config(junk(1, 24'($urandom_range(0, 3) != 0)), junk(2, 24'(mode)),
					junk(6, 24'($urandom_range(0, 63))), junk(6, 24'($urandom_range(0, 63))),
					junk(6, 24'($urandom_range(0, 63))), junk(6, 24'($urandom_range(0, 63))),
					junk(6, 24'($urandom_range(0, 40))), 24'($urandom));
			end
			if (ph == 2) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else begin
				in_idle_pct = idle_levels[$urandom_range(0, 3)];
				out_idle_pct = idle_levels[$urandom_range(0, 3)];
			end
			repeat (RAND_ITEMS) vox_q.push_back(random_vox());
			drain();
		end

		$display("Sent %0d voxels over %0d register settings, checked %0d colours.",
			n_sent, RAND_SETS + 3, n_checked);
		$display("Of these %0d hidden by the slice, %0d hue colored, %0d on the marker.",
			n_hidden, n_hue, n_marker);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
